FILE: rtl/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and codes for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // pixel formats
    localparam logic [1:0] FMT_OTHER  = 2'd0;
    localparam logic [1:0] FMT_RGB24  = 2'd1;
    localparam logic [1:0] FMT_RGBA32 = 2'd2;

    // header field values
    localparam logic [7:0] IMG_RAW  = 8'd2;
    localparam logic [7:0] IMG_RLE  = 8'd10;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    // header byte positions
    localparam logic [4:0] HB_ID_LEN    = 5'd0;
    localparam logic [4:0] HB_CMAP      = 5'd1;
    localparam logic [4:0] HB_KIND      = 5'd2;
    localparam logic [4:0] HB_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HB_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HB_DEPTH     = 5'd16;
    localparam logic [4:0] HB_DESC      = 5'd17;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } tgarle_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  pixel_format;
        logic        flip_needed;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic        last_pixel;
    } tgarle_out_t;

    // per-cycle handshake between the parser and the stages around it
    typedef struct packed {
        logic take;   // the registered request is consumed this cycle
        logic load;   // and it writes a result
    } tgarle_step_t;

endpackage

FILE: rtl/tgarle_core.sv
// ----------------------------------------------------------------------------
// tgarle_core
// Byte parser: header fields, comment skip, packet headers and pixel assembly.
// Updates state for one request per cycle unless its result waits on out_free.
// ----------------------------------------------------------------------------
module tgarle_core import tgarle_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         item_valid,
    input  tgarle_in_t   item,
    input  logic         out_free,
    output tgarle_step_t step,
    output tgarle_out_t  result
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_COMMENT = 3'd2;
    localparam logic [2:0] PH_PACKET  = 3'd3;
    localparam logic [2:0] PH_PIXEL   = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    localparam logic [4:0] HDR_LAST = 5'd17;

    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  comment_left_reg, comment_left_next;
    logic        cmap_zero_reg, cmap_zero_next;
    logic        kind_ok_reg, kind_ok_next;
    logic        kind_rle_reg, kind_rle_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic        descriptor_bit5_reg, descriptor_bit5_next;
    logic [31:0] pixels_left_reg, pixels_left_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic        pkt_run_reg, pkt_run_next;
    logic [23:0] pix_bytes_reg, pix_bytes_next;
    logic [1:0]  pix_idx_reg, pix_idx_next;

    logic [7:0]  b;
    logic [2:0]  phase_cur;
    logic [4:0]  idx_cur;
    logic        do_verdict;
    logic        hdr_ok;
    logic        flip_cur;
    logic        has_res;
    logic [1:0]  last_idx;
    logic [7:0]  cnt_raw;
    logic [7:0]  cnt;
    logic [31:0] left_after;
    logic [7:0]  pkt_after;

    assign b         = item.data_byte;
    assign phase_cur = item.file_start ? PH_HEADER : phase_reg;
    assign idx_cur   = item.file_start ? HB_ID_LEN : hdr_idx_reg;
    assign hdr_ok    = (width_reg != 16'd0) && (height_reg != 16'd0) &&
                       cmap_zero_reg && kind_ok_reg;
    // descriptor is the current byte when the verdict falls on it
    assign flip_cur  = (phase_cur == PH_HEADER) ? ~b[5] : ~descriptor_bit5_reg;

    assign last_idx   = (fmt_reg == FMT_RGBA32) ? 2'd3 : 2'd2;
    assign cnt_raw    = (kind_rle_reg && pkt_run_reg) ? pkt_left_reg : 8'd1;
    assign cnt        = (pixels_left_reg < {24'd0, cnt_raw}) ? pixels_left_reg[7:0]
                                                             : cnt_raw;
    assign left_after = pixels_left_reg - {24'd0, cnt};
    assign pkt_after  = (pkt_run_reg || pkt_left_reg <= 8'd1) ? 8'd0
                                                              : pkt_left_reg - 8'd1;

    always_comb begin
        phase_next           = phase_reg;
        hdr_idx_next         = hdr_idx_reg;
        comment_left_next    = comment_left_reg;
        cmap_zero_next       = cmap_zero_reg;
        kind_ok_next         = kind_ok_reg;
        kind_rle_next        = kind_rle_reg;
        width_next           = width_reg;
        height_next          = height_reg;
        fmt_next             = fmt_reg;
        descriptor_bit5_next = descriptor_bit5_reg;
        pixels_left_next     = pixels_left_reg;
        pkt_left_next        = pkt_left_reg;
        pkt_run_next         = pkt_run_reg;
        pix_bytes_next       = pix_bytes_reg;
        pix_idx_next         = pix_idx_reg;
        do_verdict           = 1'b0;
        has_res              = 1'b0;
        result               = '0;

        unique case (phase_cur)
            PH_HEADER: begin
                phase_next   = PH_HEADER;
                hdr_idx_next = idx_cur + 5'd1;
                unique case (idx_cur)
                    HB_ID_LEN:    comment_left_next = b;
                    HB_CMAP:      cmap_zero_next = (b == 8'd0);
                    HB_KIND: begin
                        kind_ok_next  = (b == IMG_RAW) || (b == IMG_RLE);
                        kind_rle_next = (b == IMG_RLE);
                    end
                    HB_WIDTH_LO:  width_next  = {width_reg[15:8], b};
                    HB_WIDTH_HI:  width_next  = {b, width_reg[7:0]};
                    HB_HEIGHT_LO: height_next = {height_reg[15:8], b};
                    HB_HEIGHT_HI: height_next = {b, height_reg[7:0]};
                    HB_DEPTH: begin
                        fmt_next = (b == DEPTH_32) ? FMT_RGBA32 :
                                   (b == DEPTH_24) ? FMT_RGB24 : FMT_OTHER;
                    end
                    HB_DESC:      descriptor_bit5_next = b[5];
                    default: ;
                endcase
                if (idx_cur == HDR_LAST) begin
                    if (comment_left_reg != 8'd0) begin
                        phase_next = PH_COMMENT;
                    end else begin
                        do_verdict = 1'b1;
                    end
                end
            end
            PH_COMMENT: begin
                comment_left_next = comment_left_reg - 8'd1;
                if (comment_left_reg == 8'd1) begin
                    do_verdict = 1'b1;
                end
            end
            PH_PACKET: begin
                pkt_left_next = {1'b0, b[6:0]} + 8'd1;
                pkt_run_next  = b[7];
                pix_idx_next  = 2'd0;
                phase_next    = PH_PIXEL;
            end
            PH_PIXEL: begin
                if (pix_idx_reg != last_idx) begin
                    unique case (pix_idx_reg)
                        2'd0:    pix_bytes_next[7:0]   = b;
                        2'd1:    pix_bytes_next[15:8]  = b;
                        default: pix_bytes_next[23:16] = b;
                    endcase
                    pix_idx_next = pix_idx_reg + 2'd1;
                end else begin
                    has_res             = 1'b1;
                    pix_idx_next        = 2'd0;
                    result.result_kind  = KIND_PIXEL;
                    result.blue         = pix_bytes_reg[7:0];
                    result.green        = pix_bytes_reg[15:8];
                    if (fmt_reg == FMT_RGBA32) begin
                        result.red   = pix_bytes_reg[23:16];
                        result.alpha = b;
                    end else begin
                        result.red   = b;
                        result.alpha = 8'd0;
                    end
                    result.repeat_count = cnt;
                    result.last_pixel   = (left_after == 32'd0);
                    pixels_left_next    = left_after;
                    if (kind_rle_reg) begin
                        pkt_left_next = pkt_after;
                        if (pkt_after == 8'd0) begin
                            phase_next = PH_PACKET;
                        end
                    end
                    if (left_after == 32'd0) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            default: ;
        endcase

        if (do_verdict) begin
            has_res             = 1'b1;
            result.result_kind  = hdr_ok ? KIND_HEADER : KIND_ERROR;
            result.image_width  = width_reg;
            result.image_height = height_reg;
            result.pixel_format = fmt_reg;
            result.flip_needed  = flip_cur;
            phase_next          = PH_DONE;
            if (hdr_ok && fmt_reg != FMT_OTHER) begin
                pixels_left_next = {16'd0, width_reg} * {16'd0, height_reg};
                pix_idx_next     = 2'd0;
                pkt_left_next    = 8'd0;
                pkt_run_next     = 1'b0;
                phase_next       = kind_rle_reg ? PH_PACKET : PH_PIXEL;
            end
        end
    end

    assign step.take = item_valid && (!has_res || out_free);
    assign step.load = step.take && has_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            hdr_idx_reg      <= '0;
            comment_left_reg <= '0;
            pixels_left_reg  <= '0;
            pkt_left_reg     <= '0;
            pkt_run_reg      <= 1'b0;
            pix_idx_reg      <= '0;
        end else if (step.take) begin
            phase_reg        <= phase_next;
            hdr_idx_reg      <= hdr_idx_next;
            comment_left_reg <= comment_left_next;
            pixels_left_reg  <= pixels_left_next;
            pkt_left_reg     <= pkt_left_next;
            pkt_run_reg      <= pkt_run_next;
            pix_idx_reg      <= pix_idx_next;
        end
    end

    // header fields and pixel bytes are payload
    always_ff @(posedge aclk) begin
        if (step.take) begin
            cmap_zero_reg       <= cmap_zero_next;
            kind_ok_reg         <= kind_ok_next;
            kind_rle_reg        <= kind_rle_next;
            width_reg           <= width_next;
            height_reg          <= height_next;
            fmt_reg             <= fmt_next;
            descriptor_bit5_reg <= descriptor_bit5_next;
            pix_bytes_reg       <= pix_bytes_next;
        end
    end

    a_pixel_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIXEL |-> pixels_left_reg != 32'd0)
        else $error("pixel phase with no pixels left");

    a_byte_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIXEL && fmt_reg != FMT_RGBA32 |-> pix_idx_reg != 2'd3)
        else $error("byte index past 24-bit pixel");

    a_rle_packet_live: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PIXEL && kind_rle_reg
            |-> pkt_left_reg != 8'd0 && pkt_left_reg <= 8'd128)
        else $error("packet count out of range in pixel phase");

    a_last_ends_image: assert property (@(posedge aclk) disable iff (!aresetn)
        step.load && result.result_kind == KIND_PIXEL && result.last_pixel
            |=> phase_reg == PH_DONE)
        else $error("image not closed after last pixel");

endmodule

FILE: rtl/tgarle_out_buf.sv
// ----------------------------------------------------------------------------
// tgarle_out_buf
// Result register on the m_ side; frees itself as the request is taken.
// ----------------------------------------------------------------------------
module tgarle_out_buf import tgarle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  tgarle_out_t result,
    output logic        out_free,
    output logic        m_valid,
    input  logic        m_ready,
    output tgarle_out_t m_data
);

    logic        m_valid_reg, m_valid_next;
    tgarle_out_t m_data_reg;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA stream decoder: header, comment skip, raw/RLE 24/32-bit pixels.
// Throughput: one byte per cycle while the result side keeps up.
// Path: the last byte of a result goes through the input register, then the
// result register that drives m_valid.
// Reset: synchronous active-low aresetn; parser waits for a file start.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder import tgarle_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  tgarle_in_t  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output tgarle_out_t m_data
);

    logic         in_valid_reg, in_valid_next;
    tgarle_in_t   in_item_reg;
    logic         out_free;
    tgarle_step_t step;
    tgarle_out_t  result;

    // take a new byte when the held one is empty or moves on this cycle
    assign s_ready = !in_valid_reg || step.take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step.take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    tgarle_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .out_free   (out_free),
        .step       (step),
        .result     (result)
    );

    tgarle_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step.load),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
